@@ sv/rfrp_pkg.sv @@
`default_nettype none
package rfrp_pkg;

    localparam int EPC_BYTES   = 12;
    localparam int MAX_TAGS    = 8;
    localparam int FRAME_BYTES = 64;

    localparam int MAX_PARAM   = FRAME_BYTES - 7;
    localparam int PRM_KEEP    = EPC_BYTES + 3;
    localparam int STORE_DEPTH = MAX_TAGS * EPC_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SLOT_W      = $clog2(MAX_TAGS);
    localparam int CNT_W       = $clog2(MAX_TAGS + 1);
    localparam int LEN_W       = $clog2(MAX_PARAM + 1);
    localparam int KEEP_W      = $clog2(PRM_KEEP);
    localparam int EPC_W       = $clog2(EPC_BYTES);
    localparam int ELEN_W      = $clog2(EPC_BYTES + 1);
    localparam int SUM_W       = 15;

    localparam logic [7:0] HDR_BYTE    = 8'hBB;
    localparam logic [7:0] END_BYTE    = 8'h7E;
    localparam logic [7:0] TYPE_INFO   = 8'h01;
    localparam logic [7:0] TYPE_TAG    = 8'h02;
    localparam logic [7:0] CMD_INV     = 8'h22;
    localparam logic [7:0] CMD_GET_PWR = 8'hB7;
    localparam logic [7:0] CMD_SET_PWR = 8'hB6;
    localparam logic [7:0] CMD_NO_TAG  = 8'hFF;
    localparam int         TAG_HDR_LEN = 5;

    localparam logic [16:0] DIV100_MUL   = 17'd83887;
    localparam int          DIV100_SHIFT = 23;
    localparam logic [7:0]  TMO_RESET    = 8'd3;

    localparam logic [2:0] OP_RX    = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_CHECK = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_CSUM     = 4'd1;
    localparam logic [3:0] EV_FRAMING  = 4'd2;
    localparam logic [3:0] EV_NO_TAG   = 4'd3;
    localparam logic [3:0] EV_POWER    = 4'd4;
    localparam logic [3:0] EV_SET_STAT = 4'd5;
    localparam logic [3:0] EV_STORED   = 4'd6;
    localparam logic [3:0] EV_FULL     = 4'd7;
    localparam logic [3:0] EV_EPC_LONG = 4'd8;
    localparam logic [3:0] EV_UNK_TYPE = 4'd9;
    localparam logic [3:0] EV_IGNORED  = 4'd10;
    localparam logic [3:0] EV_TIMEOUT  = 4'd11;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] rx_byte;
        logic [2:0] slot;
        logic [3:0] byte_index;
    } t_in;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [9:0]  tx_power;
        logic [7:0]  status_byte;
        logic [7:0]  rssi;
        logic [15:0] tag_pc;
        logic [3:0]  tag_count;
        logic        changed;
        logic [7:0]  read_byte;
    } t_out;

    typedef enum logic [2:0] {
        PS_HEADER, PS_TYPE, PS_CMD, PS_LENH, PS_LENL, PS_PARAM, PS_CSUM, PS_END
    } t_pstate;

    typedef enum logic [2:0] {
        CS_IDLE, CS_EXEC, CS_COPY, CS_READ, CS_DONE
    } t_cstate;

    typedef struct packed {
        logic capture;
        logic exec;
        logic copy;
        logic read_done;
    } t_cmd;

    typedef struct packed {
        logic need_copy;
        logic need_read;
        logic copy_last;
    } t_sts;

endpackage
`default_nettype wire

@@ sv/rfid_reader_frame_parser.sv @@
// Reader reply deframer with a tag store. One transaction is taken at a time; after
// acceptance it passes through the execute state and, where needed, a copy or read state
// before its result is offered. A tag record that is stored passes through the copy state,
// where its twelve EPC bytes are written into the store memory one byte per cycle, and a
// read of a stored byte passes through the read state for the registered memory read. The
// next transaction is accepted in the cycle after the result is taken.
`default_nettype none
module rfid_reader_frame_parser
    import rfrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in        i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out            o_out
);

    t_cmd                w_cmd;
    t_sts                w_sts;
    logic                w_ram_we;
    logic [STORE_AW-1:0] w_ram_waddr;
    logic [7:0]          w_ram_wdata;
    logic [STORE_AW-1:0] w_ram_raddr;
    logic [7:0]          w_ram_rdata;

    rfrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rfrp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (w_sts),
        .o_out       (o_out),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    rfrp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule
`default_nettype wire

@@ sv/rfrp_ram.sv @@
`default_nettype none
module rfrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/rfrp_ctrl.sv @@
`default_nettype none
module rfrp_ctrl
    import rfrp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_cstate r_state;
    t_cstate n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            CS_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = CS_EXEC;
                end
            end
            CS_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_copy) begin
                    n_state = CS_COPY;
                end else if (i_sts.need_read) begin
                    n_state = CS_READ;
                end else begin
                    n_state = CS_DONE;
                end
            end
            CS_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = CS_DONE;
                end
            end
            CS_READ: begin
                o_cmd.read_done = 1'b1;
                n_state         = CS_DONE;
            end
            CS_DONE: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/rfrp_datapath.sv @@
`default_nettype none
module rfrp_datapath
    import rfrp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_in                 i_in,
    input  wire t_cmd                i_cmd,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_wdata,
    output t_sts                     o_sts,
    output t_out                     o_out,
    output logic                     o_ram_we,
    output logic [STORE_AW-1:0]      o_ram_waddr,
    output logic [7:0]               o_ram_wdata,
    output logic [STORE_AW-1:0]      o_ram_raddr,
    input  wire logic [7:0]          i_ram_rdata
);

    t_in                r_in,    n_in;
    t_out               r_out,   n_out;
    t_pstate            r_pstate, n_pstate;
    logic [7:0]         r_lenh,  n_lenh;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic [LEN_W-1:0]   r_pcnt,  n_pcnt;
    logic [7:0]         r_csum,  n_csum;
    logic               r_csok,  n_csok;
    logic [7:0]         r_type,  n_type;
    logic [7:0]         r_cmd,   n_cmd;
    logic [7:0]         r_prm [PRM_KEEP];
    logic [7:0]         n_prm [PRM_KEEP];
    logic [7:0]         r_tmo,   n_tmo;
    logic [7:0]         r_reload;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [MAX_TAGS-1:0] r_rowv, n_rowv;
    logic [SUM_W-1:0]   r_run,   n_run;
    logic [SUM_W-1:0]   r_last,  n_last;
    logic [EPC_W-1:0]   r_k,     n_k;
    logic [ELEN_W-1:0]  r_elen,  n_elen;
    logic [SLOT_W-1:0]  r_wslot, n_wslot;
    logic               r_rd_ok, n_rd_ok;

    logic [32:0]        w_prod;
    logic [7:0]         w_cbyte;
    logic               w_store;
    logic               w_tag_ok;

    assign w_prod = 33'({r_prm[0], r_prm[1]}) * 33'(DIV100_MUL);

    assign w_tag_ok = (int'(r_len) >= TAG_HDR_LEN) &&
                      (int'(r_len) - TAG_HDR_LEN <= EPC_BYTES);

    assign w_store = (r_in.operation == OP_RX) && (r_pstate == PS_END) &&
                     (r_in.rx_byte == END_BYTE) && r_csok &&
                     (r_type == TYPE_TAG) && (r_cmd == CMD_INV) && w_tag_ok &&
                     (int'(r_count) < MAX_TAGS);

    assign w_cbyte = (ELEN_W'(r_k) < r_elen) ?
                     r_prm[KEEP_W'(r_k) + KEEP_W'(3)] : 8'd0;

    assign o_sts.need_copy = w_store;
    assign o_sts.need_read = (r_in.operation == OP_READ);
    assign o_sts.copy_last = (int'(r_k) == EPC_BYTES - 1);

    assign o_ram_we    = i_cmd.copy;
    assign o_ram_waddr = STORE_AW'(r_wslot) * STORE_AW'(EPC_BYTES) + STORE_AW'(r_k);
    assign o_ram_wdata = w_cbyte;
    assign o_ram_raddr = STORE_AW'(r_in.slot) * STORE_AW'(EPC_BYTES) +
                         STORE_AW'(r_in.byte_index);

    assign o_out = r_out;

    always_comb begin
        logic [15:0] v_pl;
        logic [LEN_W-1:0] v_pcnt;
        n_in     = r_in;
        n_out    = r_out;
        n_pstate = r_pstate;
        n_lenh   = r_lenh;
        n_len    = r_len;
        n_pcnt   = r_pcnt;
        n_csum   = r_csum;
        n_csok   = r_csok;
        n_type   = r_type;
        n_cmd    = r_cmd;
        n_prm    = r_prm;
        n_tmo    = r_tmo;
        n_count  = r_count;
        n_rowv   = r_rowv;
        n_run    = r_run;
        n_last   = r_last;
        n_k      = r_k;
        n_elen   = r_elen;
        n_wslot  = r_wslot;
        n_rd_ok  = r_rd_ok;
        v_pl     = {r_lenh, r_in.rx_byte};
        v_pcnt   = r_pcnt + LEN_W'(1);

        if (i_cmd.capture) begin
            n_in = i_in;
        end

        if (i_cmd.exec) begin
            n_out = '0;
            case (r_in.operation)
                OP_RX: begin
                    case (r_pstate)
                        PS_HEADER: begin
                            if (r_in.rx_byte == HDR_BYTE) begin
                                n_pcnt   = '0;
                                n_csum   = '0;
                                n_pstate = PS_TYPE;
                            end
                        end
                        PS_TYPE: begin
                            n_type   = r_in.rx_byte;
                            n_csum   = r_csum + r_in.rx_byte;
                            n_pstate = PS_CMD;
                        end
                        PS_CMD: begin
                            n_cmd    = r_in.rx_byte;
                            n_csum   = r_csum + r_in.rx_byte;
                            n_pstate = PS_LENH;
                        end
                        PS_LENH: begin
                            n_lenh   = r_in.rx_byte;
                            n_csum   = r_csum + r_in.rx_byte;
                            n_pstate = PS_LENL;
                        end
                        PS_LENL: begin
                            n_csum = r_csum + r_in.rx_byte;
                            if (v_pl == 16'd0 || int'(v_pl) > MAX_PARAM) begin
                                n_pstate        = PS_HEADER;
                                n_out.event_res = EV_FRAMING;
                            end else begin
                                n_len    = LEN_W'(v_pl);
                                n_pstate = PS_PARAM;
                            end
                        end
                        PS_PARAM: begin
                            n_csum = r_csum + r_in.rx_byte;
                            if (int'(r_pcnt) < PRM_KEEP) begin
                                n_prm[KEEP_W'(r_pcnt)] = r_in.rx_byte;
                            end
                            n_pcnt = v_pcnt;
                            if (v_pcnt >= r_len) begin
                                n_pstate = PS_CSUM;
                            end
                        end
                        PS_CSUM: begin
                            n_csok   = (r_in.rx_byte == r_csum);
                            n_pstate = PS_END;
                        end
                        PS_END: begin
                            n_pstate = PS_HEADER;
                            if (r_in.rx_byte != END_BYTE) begin
                                n_out.event_res = EV_FRAMING;
                            end else if (!r_csok) begin
                                n_out.event_res = EV_CSUM;
                            end else begin
                                n_tmo = r_reload;
                                if (r_type == TYPE_INFO) begin
                                    if (r_cmd == CMD_NO_TAG && r_len == LEN_W'(1)) begin
                                        n_out.event_res   = EV_NO_TAG;
                                        n_out.status_byte = r_prm[0];
                                    end else if (r_cmd == CMD_GET_PWR &&
                                                 r_len == LEN_W'(2)) begin
                                        n_out.event_res = EV_POWER;
                                        n_out.tx_power  = w_prod[DIV100_SHIFT +: 10];
                                    end else if (r_cmd == CMD_SET_PWR &&
                                                 r_len == LEN_W'(1)) begin
                                        n_out.event_res   = EV_SET_STAT;
                                        n_out.status_byte = r_prm[0];
                                    end else begin
                                        n_out.event_res = EV_IGNORED;
                                    end
                                end else if (r_type == TYPE_TAG) begin
                                    if (r_cmd != CMD_INV) begin
                                        n_out.event_res = EV_IGNORED;
                                    end else if (!w_tag_ok) begin
                                        n_out.event_res = EV_EPC_LONG;
                                    end else begin
                                        n_out.rssi   = r_prm[0];
                                        n_out.tag_pc = {r_prm[1], r_prm[2]};
                                        if (w_store) begin
                                            n_out.event_res = EV_STORED;
                                            n_count = r_count + CNT_W'(1);
                                            n_elen  = ELEN_W'(r_len - LEN_W'(TAG_HDR_LEN));
                                            n_wslot = SLOT_W'(r_count);
                                            n_k     = '0;
                                        end else begin
                                            n_out.event_res = EV_FULL;
                                        end
                                    end
                                end else begin
                                    n_out.event_res = EV_UNK_TYPE;
                                end
                            end
                        end
                        default: begin
                            n_pstate = PS_HEADER;
                        end
                    endcase
                end
                OP_TICK: begin
                    if (r_tmo != 8'd0) begin
                        n_tmo = r_tmo - 8'd1;
                    end else begin
                        n_pstate        = PS_HEADER;
                        n_out.event_res = EV_TIMEOUT;
                    end
                end
                OP_START: begin
                    n_rowv  = '0;
                    n_count = '0;
                    n_run   = '0;
                end
                OP_CHECK: begin
                    n_out.changed = (r_run != r_last);
                    n_last        = r_run;
                end
                OP_READ: begin
                    n_rd_ok = (int'(r_in.byte_index) < EPC_BYTES) &&
                              (int'(r_in.slot) < MAX_TAGS) &&
                              r_rowv[SLOT_W'(r_in.slot)];
                end
                default: begin
                    n_out.event_res = EV_NONE;
                end
            endcase
            n_out.tag_count = 4'(n_count);
        end

        if (i_cmd.copy) begin
            n_run = r_run + SUM_W'(w_cbyte);
            n_k   = r_k + EPC_W'(1);
            if (int'(r_k) == EPC_BYTES - 1) begin
                n_rowv[r_wslot] = 1'b1;
            end
        end

        if (i_cmd.read_done) begin
            n_out.read_byte = r_rd_ok ? i_ram_rdata : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate <= PS_HEADER;
            r_tmo    <= TMO_RESET;
            r_reload <= TMO_RESET;
            r_count  <= '0;
            r_rowv   <= '0;
            r_run    <= '0;
            r_last   <= '0;
        end else begin
            r_pstate <= n_pstate;
            r_tmo    <= n_tmo;
            r_count  <= n_count;
            r_rowv   <= n_rowv;
            r_run    <= n_run;
            r_last   <= n_last;
            if (i_cfg_we) begin
                r_reload <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_out   <= n_out;
        r_lenh  <= n_lenh;
        r_len   <= n_len;
        r_pcnt  <= n_pcnt;
        r_csum  <= n_csum;
        r_csok  <= n_csok;
        r_type  <= n_type;
        r_cmd   <= n_cmd;
        r_prm   <= n_prm;
        r_k     <= n_k;
        r_elen  <= n_elen;
        r_wslot <= n_wslot;
        r_rd_ok <= n_rd_ok;
    end

endmodule
`default_nettype wire

@@ sv/rfrp_checker.sv @@
`default_nettype none
module rfrp_checker
    import rfrp_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_cfg_we,
    input wire logic [7:0] i_cfg_wdata,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire t_in        i_in,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire t_out       o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("Stalled result changed.");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("Result offered in the cycle after acceptance.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("Input accepted while a result is pending.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_out.tag_count) <= MAX_TAGS)
        else $error("Tag count beyond store size.");

endmodule

bind rfid_reader_frame_parser rfrp_checker u_rfrp_checker (.*);
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rfrp_pkg::*;

    class tag_store_scoreboard;
        logic [7:0] reload;
        logic [7:0] tmo;
        t_pstate    ps;
        logic [7:0] fs[FRAME_BYTES];
        int         fidx;
        int         pcnt;
        logic [7:0] epc[MAX_TAGS][EPC_BYTES];
        int         ntags;
        int         rsum;
        int         lsum;
        t_out       pending[$];
        int         errors;
        int         n_checked;
        int         n_stored;
        int         n_full;
        int         n_tmo;

        function new();
            reload = TMO_RESET;
            tmo = TMO_RESET;
            ps = PS_HEADER;
            fidx = 0;
            pcnt = 0;
            ntags = 0;
            rsum = 0;
            lsum = 0;
            errors = 0;
            n_checked = 0;
            n_stored = 0;
            n_full = 0;
            n_tmo = 0;
            foreach (epc[s, k]) epc[s][k] = 8'd0;
        endfunction

        function int plen();
            return int'({fs[3], fs[4]});
        endfunction

        function void put(logic [7:0] b);
            if (fidx < FRAME_BYTES) fs[fidx] = b;
            fidx++;
        endfunction

        function void decode(inout t_out r);
            int         pl;
            int         elen;
            logic [7:0] sum;
            logic [7:0] b;
            pl = plen();
            sum = 8'd0;
            ps = PS_HEADER;
            for (int i = 1; i < 5 + pl; i++) sum += fs[i];
            if (sum != fs[5 + pl]) begin
                r.event_res = EV_CSUM;
                return;
            end
            tmo = reload;
            if (fs[1] == TYPE_INFO) begin
                if (fs[2] == CMD_NO_TAG && pl == 1) begin
                    r.event_res = EV_NO_TAG;
                    r.status_byte = fs[5];
                end else if (fs[2] == CMD_GET_PWR && pl == 2) begin
                    r.event_res = EV_POWER;
                    r.tx_power = 10'(int'({fs[5], fs[6]}) / 100);
                end else if (fs[2] == CMD_SET_PWR && pl == 1) begin
                    r.event_res = EV_SET_STAT;
                    r.status_byte = fs[5];
                end else begin
                    r.event_res = EV_IGNORED;
                end
            end else if (fs[1] == TYPE_TAG) begin
                if (fs[2] != CMD_INV) begin
                    r.event_res = EV_IGNORED;
                end else if (pl < TAG_HDR_LEN || pl - TAG_HDR_LEN > EPC_BYTES) begin
                    r.event_res = EV_EPC_LONG;
                end else begin
                    elen = pl - TAG_HDR_LEN;
                    r.rssi = fs[5];
                    r.tag_pc = {fs[6], fs[7]};
                    if (ntags < MAX_TAGS) begin
                        for (int i = 0; i < EPC_BYTES; i++) begin
                            b = (i < elen) ? fs[8 + i] : 8'd0;
                            epc[ntags][i] = b;
                            rsum += b;
                        end
                        ntags++;
                        r.event_res = EV_STORED;
                        n_stored++;
                    end else begin
                        r.event_res = EV_FULL;
                        n_full++;
                    end
                end
            end else begin
                r.event_res = EV_UNK_TYPE;
            end
        endfunction

        function void rx(logic [7:0] b, inout t_out r);
            case (ps)
                PS_HEADER: begin
                    if (b == HDR_BYTE) begin
                        pcnt = 0;
                        fidx = 0;
                        put(b);
                        ps = PS_TYPE;
                    end
                end
                PS_TYPE: begin
                    put(b);
                    ps = PS_CMD;
                end
                PS_CMD: begin
                    put(b);
                    ps = PS_LENH;
                end
                PS_LENH: begin
                    put(b);
                    ps = PS_LENL;
                end
                PS_LENL: begin
                    put(b);
                    if (plen() == 0 || plen() > MAX_PARAM) begin
                        ps = PS_HEADER;
                        r.event_res = EV_FRAMING;
                    end else begin
                        ps = PS_PARAM;
                    end
                end
                PS_PARAM: begin
                    put(b);
                    pcnt++;
                    if (pcnt >= plen()) ps = PS_CSUM;
                end
                PS_CSUM: begin
                    put(b);
                    ps = PS_END;
                end
                default: begin
                    if (b == END_BYTE) begin
                        put(b);
                        decode(r);
                    end else begin
                        ps = PS_HEADER;
                        r.event_res = EV_FRAMING;
                    end
                end
            endcase
        endfunction

        function void note_input(t_in x);
            t_out r;
            r = '0;
            case (x.operation)
                OP_RX: rx(x.rx_byte, r);
                OP_TICK: begin
                    if (tmo > 0) begin
                        tmo--;
                    end else begin
                        ps = PS_HEADER;
                        fidx = 0;
                        r.event_res = EV_TIMEOUT;
                        n_tmo++;
                    end
                end
                OP_START: begin
                    foreach (epc[s, k]) epc[s][k] = 8'd0;
                    ntags = 0;
                    rsum = 0;
                end
                OP_CHECK: begin
                    r.changed = (rsum != lsum);
                    lsum = rsum;
                end
                OP_READ: begin
                    if (x.slot < MAX_TAGS && x.byte_index < EPC_BYTES)
                        r.read_byte = epc[x.slot][x.byte_index];
                end
                default: ;
            endcase
            r.tag_count = 4'(ntags);
            pending.push_back(r);
        endfunction

        function void cmp(string name, int e, int a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out a);
            t_out e;
            if (pending.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            cmp("event_res", e.event_res, a.event_res);
            cmp("tx_power", e.tx_power, a.tx_power);
            cmp("status_byte", e.status_byte, a.status_byte);
            cmp("rssi", e.rssi, a.rssi);
            cmp("tag_pc", e.tag_pc, a.tag_pc);
            cmp("tag_count", e.tag_count, a.tag_count);
            cmp("changed", e.changed, a.changed);
            cmp("read_byte", e.read_byte, a.read_byte);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in        i_in = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out       o_out;

    tag_store_scoreboard sb = new();
    t_in stim_q[$];
    bit  hold_req = 1'b0;

    rfid_reader_frame_parser dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_input(i_in);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out);
        end
    end

    int stall_cyc = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        stall_cyc++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
            i_out_stall <= 1'b1;
        end else begin
            case ((stall_cyc / 97) % 4)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 9) < 3);
                2: i_out_stall <= stall_cyc[0];
                default: i_out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    int idle_cyc = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cyc = 0;
        end else begin
            idle_cyc++;
            if (idle_cyc >= 5000) begin
                $display("rfid_reader_frame_parser verification failed");
                $finish;
            end
        end
    end

    function automatic void push_op(logic [2:0] op, logic [7:0] b);
        t_in x;
        x.operation = op;
        x.rx_byte = b;
        x.slot = 3'($urandom);
        x.byte_index = 4'($urandom);
        stim_q.push_back(x);
    endfunction

    function automatic void push_read(logic [2:0] s, logic [3:0] k);
        t_in x;
        x.operation = OP_READ;
        x.rx_byte = 8'($urandom);
        x.slot = s;
        x.byte_index = k;
        stim_q.push_back(x);
    endfunction

    // A corrupt value of 1 spoils the checksum, 2 spoils the end byte.
    function automatic void push_frame(logic [7:0] ftype, logic [7:0] cmd,
                                       logic [7:0] prm[$], int corrupt);
        logic [7:0] sum;
        logic [15:0] len;
        len = 16'(prm.size());
        sum = ftype + cmd + len[15:8] + len[7:0];
        push_op(OP_RX, HDR_BYTE);
        push_op(OP_RX, ftype);
        push_op(OP_RX, cmd);
        push_op(OP_RX, len[15:8]);
        push_op(OP_RX, len[7:0]);
        foreach (prm[i]) begin
            push_op(OP_RX, prm[i]);
            sum += prm[i];
        end
        push_op(OP_RX, (corrupt == 1) ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum);
        push_op(OP_RX, (corrupt == 2) ? 8'($urandom_range(0, 125)) : END_BYTE);
    endfunction

    function automatic void push_tag(int plen_n, int corrupt);
        logic [7:0] prm[$];
        for (int i = 0; i < plen_n; i++) prm.push_back(8'($urandom));
        push_frame(TYPE_TAG, CMD_INV, prm, corrupt);
    endfunction

    function automatic void push_short(logic [7:0] ftype, logic [7:0] cmd, int n, int corrupt);
        logic [7:0] prm[$];
        for (int i = 0; i < n; i++) prm.push_back(8'($urandom));
        push_frame(ftype, cmd, prm, corrupt);
    endfunction

    function automatic void build_directed();
        logic [7:0] prm[$];
        push_short(TYPE_INFO, CMD_NO_TAG, 1, 0);
        prm = '{8'hFF, 8'hFF};
        push_frame(TYPE_INFO, CMD_GET_PWR, prm, 0);
        prm = '{8'h00, 8'h00};
        push_frame(TYPE_INFO, CMD_GET_PWR, prm, 0);
        prm = '{8'hFF, 8'hDB};
        push_frame(TYPE_INFO, CMD_GET_PWR, prm, 0);
        push_short(TYPE_INFO, CMD_SET_PWR, 1, 0);
        push_tag(TAG_HDR_LEN, 0);
        push_tag(TAG_HDR_LEN + EPC_BYTES, 0);
        push_tag(TAG_HDR_LEN + EPC_BYTES + 1, 0);
        push_tag(TAG_HDR_LEN - 1, 0);
        push_short(8'h03, CMD_INV, 2, 0);
        push_short(TYPE_INFO, CMD_INV, 1, 0);
        push_short(TYPE_TAG, CMD_NO_TAG, 6, 0);
        push_short(TYPE_INFO, CMD_NO_TAG, 1, 1);
        push_short(TYPE_INFO, CMD_SET_PWR, 1, 2);
        push_short(TYPE_TAG, CMD_INV, MAX_PARAM, 0);
        for (int i = 0; i < 3; i++) begin
            logic [15:0] bad;
            bad = (i == 0) ? 16'h0000 : (i == 1) ? 16'(MAX_PARAM + 1) : 16'hFFFF;
            push_op(OP_RX, HDR_BYTE);
            push_op(OP_RX, TYPE_INFO);
            push_op(OP_RX, CMD_NO_TAG);
            push_op(OP_RX, bad[15:8]);
            push_op(OP_RX, bad[7:0]);
        end
        push_op(OP_CHECK, 8'h00);
        push_op(OP_CHECK, 8'hFF);
        push_read(3'd1, 4'd0);
        push_read(3'd7, 4'(EPC_BYTES - 1));
        push_read(3'd0, 4'd15);
        push_read(3'd2, 4'(EPC_BYTES));
        push_op(OP_RX, HDR_BYTE);
        push_op(OP_RX, TYPE_TAG);
        for (int i = 0; i < 5; i++) push_op(OP_TICK, 8'($urandom));
        push_short(TYPE_INFO, CMD_NO_TAG, 1, 0);
        push_op(OP_START, 8'h00);
        push_op(OP_CHECK, 8'h00);
        push_op(3'd5, 8'h00);
        push_op(3'd6, 8'h00);
        push_op(3'd7, 8'hFF);
    endfunction

    function automatic void build_random(int count);
        int r;
        while (stim_q.size() < count) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                push_tag($urandom_range(0, 9) == 0 ? $urandom_range(1, 20)
                         : TAG_HDR_LEN + $urandom_range(0, EPC_BYTES),
                         $urandom_range(0, 19) == 0 ? $urandom_range(1, 2) : 0);
            end else if (r < 50) begin
                case ($urandom_range(0, 4))
                    0: push_short(TYPE_INFO, CMD_NO_TAG, 1, 0);
                    1: push_short(TYPE_INFO, CMD_GET_PWR, 2, 0);
                    2: push_short(TYPE_INFO, CMD_SET_PWR, 1, 0);
                    3: push_short(8'($urandom), 8'($urandom), $urandom_range(1, 8),
                                  $urandom_range(0, 2));
                    default: push_short(TYPE_INFO, $urandom_range(0, 1) ? CMD_GET_PWR
                                        : CMD_NO_TAG, $urandom_range(1, 4), 0);
                endcase
            end else if (r < 60) begin
                push_op(OP_TICK, 8'($urandom));
            end else if (r < 63) begin
                push_op(OP_START, 8'($urandom));
            end else if (r < 71) begin
                push_op(OP_CHECK, 8'($urandom));
            end else if (r < 88) begin
                push_read(3'($urandom), 4'($urandom_range(0, 15)));
            end else if (r < 96) begin
                push_op(OP_RX, $urandom_range(0, 3) == 0 ? HDR_BYTE : 8'($urandom));
            end else begin
                push_op(3'($urandom_range(5, 7)), 8'($urandom));
            end
        end
    endfunction

    task automatic send_all();
        int burst;
        burst = 0;
        while (stim_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
            i_in_valid <= 1'b1;
            i_in <= stim_q.pop_front();
            burst--;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reload(logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.reload = v;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] reloads[4];
        reloads = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd1};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        build_directed();
        send_all();
        drain();
        build_random(250);
        send_all();
        drain();
        foreach (reloads[p]) begin
            write_reload(reloads[p]);
            build_random(230);
            if (p == 1) hold_req = 1'b1;
            send_all();
            drain();
        end
        $display("Checked %0d transactions over five timeout settings: %0d tags stored,",
                 sb.n_checked, sb.n_stored);
        $display("%0d rejected as store full, %0d timeouts.", sb.n_full, sb.n_tmo);
        if (sb.errors == 0) begin
            $display("rfid_reader_frame_parser verification clean");
        end else begin
            $display("rfid_reader_frame_parser verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
sv/rfrp_pkg.sv
sv/rfrp_ram.sv
sv/rfrp_ctrl.sv
sv/rfrp_datapath.sv
sv/rfid_reader_frame_parser.sv
sv/rfrp_checker.sv
dv/testbench.sv
